// File: sv/bba_pkg.sv
// ============================================================================
// Bitmap block allocator package
// Shared types, codes and helper functions for the allocator controller,
// datapath and top level.
// ============================================================================
package bba_pkg;

    // Map geometry.
    localparam int NUM_BLOCKS   = 4096;
    localparam int WORD_BITS    = 32;
    localparam int MAP_WORDS    = NUM_BLOCKS / WORD_BITS;
    localparam int WORD_AW      = $clog2(MAP_WORDS);
    localparam int BIT_AW       = $clog2(WORD_BITS);
    localparam int INDEX_W      = 12;
    localparam int COUNT_W      = 13;

    // The summary scan looks at eight words per cycle.
    localparam int GROUP_LANES  = 8;
    localparam int LANE_AW      = $clog2(GROUP_LANES);
    localparam int GROUP_AW     = WORD_AW - LANE_AW;

    localparam logic [WORD_BITS-1:0] FULL_WORD   = '1;
    localparam logic [COUNT_W-1:0]   COUNT_MAX   = '1;
    localparam logic [COUNT_W-1:0]   TOTAL_RESET = COUNT_W'(NUM_BLOCKS);
    localparam logic [COUNT_W:0]     MAP_END     = (COUNT_W+1)'(NUM_BLOCKS);

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_RANGE = 2'd2,
        KIND_MARK  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_OOM         = 2'd1,
        STATUS_DOUBLE_FREE = 2'd2
    } status_t;

    typedef struct packed {
        kind_t                kind;
        logic [INDEX_W-1:0]   block_index;
        logic [COUNT_W-1:0]   block_count;
    } in_item_t;

    typedef struct packed {
        status_t              status;
        logic [INDEX_W-1:0]   granted_block;
        logic [COUNT_W-1:0]   used_total;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC_SCAN,
        S_ALLOC_READ,
        S_ALLOC_WRITE,
        S_FREE_READ,
        S_FREE_WRITE,
        S_RANGE_READ,
        S_RANGE_CALC,
        S_RANGE_WRITE,
        S_MARK,
        S_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic rd_en;
        logic alloc_wr;
        logic free_wr;
        logic range_calc;
        logic range_wr;
        logic mark;
        logic result_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic grp_hit;
        logic grp_last;
        logic range_last;
        logic out_free;
    } dp_sts_t;

    // Population count of one map word, summed per byte.
    function automatic logic [BIT_AW:0] popcount32(input logic [WORD_BITS-1:0] word);
        logic [3:0]       byte_cnt [4];
        logic [BIT_AW:0]  total;
        total = '0;
        for (int b = 0; b < 4; b++) begin
            byte_cnt[b] = '0;
            for (int j = 0; j < 8; j++) begin
                byte_cnt[b] = byte_cnt[b] + 4'(word[b*8+j]);
            end
        end
        total = (BIT_AW+1)'(byte_cnt[0]) + (BIT_AW+1)'(byte_cnt[1])
              + (BIT_AW+1)'(byte_cnt[2]) + (BIT_AW+1)'(byte_cnt[3]);
        return total;
    endfunction

endpackage

// File: sv/bitmap_block_allocator_unit.sv
// ============================================================================
// Bitmap block allocator unit
// Allocate: scan the 16 summary groups in order, read the chosen word, write it
// back, load the result; out of memory ends after the last group. Free: read,
// write, result. Release range: read, calc, write per word, result. Mark all used:
// mark, result. One item at a time; next one taken in the cycle after its result.
// Reset (aresetn low, synchronous) marks every block used by clearing the word
// valid bits at once, sets the used count to 4096 and block_total to 4096.
// ============================================================================
module bitmap_block_allocator_unit
    import bba_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_item,

    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_item,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    // The map holds 4096 used bits in 128 words of 32 bits. Each word has a
    // valid bit and a not-full bit in flip-flops. A word that is not valid
    // reads as all ones, so reset and mark all used take effect without a
    // clearing pass over the memory.
    //
    // Allocation first scans the not-full summary eight words per cycle, in
    // order, over the words below floor(effective total / 32). The first word
    // with a clear bit is read, its lowest clear bit is set and its index is
    // returned. When no searched word has a clear bit the item finishes with
    // an out of memory status.
    //
    // A release range walks the touched words one by one: read, mask and
    // count the set bits in range, write the cleared word back and lower the
    // used count by that number, never below zero.

    logic [COUNT_W-1:0] block_total_reg;
    logic [COUNT_W-1:0] eff_total;
    dp_cmd_t            cmd;
    dp_sts_t            sts;

    // The single configuration register is always ready; the user must write it
    // only while the unit is idle, which the unit itself does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_total_reg <= TOTAL_RESET;
        end else if (cfg_valid) begin
            block_total_reg <= cfg_data;
        end
    end

    // A total above the map size acts as the map size.
    assign eff_total = (block_total_reg > TOTAL_RESET) ? TOTAL_RESET : block_total_reg;

    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .sts     (sts),
        .cmd     (cmd)
    );

    bba_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_item    (s_item),
        .eff_total (eff_total),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // Only one item is in flight, so input is closed right after an accept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in flight");

    // A result is never loaded over one that has not been taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result_load |-> sts.out_free)
        else $error("result register overwritten");

    // Only a successful item may carry a granted block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_item.status != STATUS_OK)) |-> (m_item.granted_block == '0))
        else $error("granted block set on a failed item");

endmodule

// File: sv/bba_ctrl.sv
// ============================================================================
// Bitmap block allocator controller
// Sequences each item through the datapath, one item at a time.
// ============================================================================
module bba_ctrl
    import bba_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  dp_sts_t  sts,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_item.kind)
                        KIND_ALLOC: state_next = S_ALLOC_SCAN;
                        KIND_FREE:  state_next = S_FREE_READ;
                        KIND_RANGE: begin
                            state_next = (s_item.block_count == '0) ? S_RESULT
                                                                     : S_RANGE_READ;
                        end
                        KIND_MARK:  state_next = S_MARK;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_ALLOC_SCAN: begin
                if (sts.grp_hit) begin
                    state_next = S_ALLOC_READ;
                end else if (sts.grp_last) begin
                    state_next = S_RESULT;
                end
            end
            S_ALLOC_READ:  state_next = S_ALLOC_WRITE;
            S_ALLOC_WRITE: state_next = S_RESULT;
            S_FREE_READ:   state_next = S_FREE_WRITE;
            S_FREE_WRITE:  state_next = S_RESULT;
            S_RANGE_READ:  state_next = S_RANGE_CALC;
            S_RANGE_CALC:  state_next = S_RANGE_WRITE;
            S_RANGE_WRITE: state_next = sts.range_last ? S_RESULT : S_RANGE_READ;
            S_MARK:        state_next = S_RESULT;
            S_RESULT: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:       state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_ALLOC_SCAN:  cmd.scan_step = 1'b1;
            S_ALLOC_READ,
            S_FREE_READ,
            S_RANGE_READ:  cmd.rd_en = 1'b1;
            S_ALLOC_WRITE: cmd.alloc_wr = 1'b1;
            S_FREE_WRITE:  cmd.free_wr = 1'b1;
            S_RANGE_CALC:  cmd.range_calc = 1'b1;
            S_RANGE_WRITE: cmd.range_wr = 1'b1;
            S_MARK:        cmd.mark = 1'b1;
            S_RESULT:      cmd.result_load = sts.out_free;
            default:       cmd = '0;
        endcase
    end

endmodule

// File: sv/bba_dpath.sv
// ============================================================================
// Bitmap block allocator datapath
// Holds the used-bit map, its valid and not-full summaries, the used count
// and the result register.
// ============================================================================
module bba_dpath
    import bba_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    input  in_item_t           s_item,
    input  logic [COUNT_W-1:0] eff_total,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_item
);

    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;
    logic [MAP_WORDS-1:0] valid_reg;
    logic [MAP_WORDS-1:0] not_full_reg;

    in_item_t             item_reg;
    logic [WORD_AW-1:0]   word_reg;
    logic [GROUP_AW-1:0]  scan_grp_reg;
    logic [WORD_AW-1:0]   last_word_reg;
    logic [BIT_AW-1:0]    last_bit_reg;
    status_t              status_reg;
    logic [INDEX_W-1:0]   granted_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic [WORD_BITS-1:0] cleared_reg;
    logic [BIT_AW:0]      pop_reg;
    logic                 m_valid_reg;
    out_item_t            m_item_reg;

    logic [GROUP_LANES-1:0] grp_bits;
    logic [LANE_AW-1:0]     grp_enc;
    logic [WORD_BITS-1:0]   rd_word;
    logic [BIT_AW-1:0]      zero_pos;
    logic [WORD_BITS-1:0]   alloc_word;
    logic                   free_bit;
    logic [WORD_BITS-1:0]   free_word;
    logic [BIT_AW-1:0]      lo_bit;
    logic [BIT_AW-1:0]      hi_bit;
    logic [WORD_BITS-1:0]   range_mask;
    logic [COUNT_W:0]       range_end;
    logic [COUNT_W:0]       range_clip;
    logic [COUNT_W:0]       range_last;
    logic                   wr_en;
    logic [WORD_BITS-1:0]   wr_data;

    // Summary scan: eight words per cycle, limited to the searched words.
    always_comb begin
        logic [WORD_AW-1:0] lane;
        grp_bits = '0;
        grp_enc  = '0;
        for (int i = 0; i < GROUP_LANES; i++) begin
            lane        = {scan_grp_reg, LANE_AW'(i)};
            grp_bits[i] = not_full_reg[lane]
                          && ({1'b0, lane} < eff_total[COUNT_W-1:BIT_AW]);
        end
        for (int i = GROUP_LANES - 1; i >= 0; i--) begin
            if (grp_bits[i]) begin
                grp_enc = LANE_AW'(i);
            end
        end
    end

    // A word that was never written since reset or mark reads as all used.
    assign rd_word = rd_valid_reg ? rd_data_reg : FULL_WORD;

    always_comb begin
        zero_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!rd_word[i]) begin
                zero_pos = BIT_AW'(i);
            end
        end
    end

    assign alloc_word = rd_word | (WORD_BITS'(1) << zero_pos);
    assign free_bit   = rd_word[item_reg.block_index[BIT_AW-1:0]];
    assign free_word  = rd_word & ~(WORD_BITS'(1) << item_reg.block_index[BIT_AW-1:0]);

    // Bits of the current word that fall inside the release range.
    assign lo_bit = (word_reg == item_reg.block_index[INDEX_W-1:BIT_AW])
                  ? item_reg.block_index[BIT_AW-1:0] : '0;
    assign hi_bit = (word_reg == last_word_reg) ? last_bit_reg : '1;
    assign range_mask = (FULL_WORD << lo_bit) & (FULL_WORD >> (BIT_AW'(WORD_BITS - 1) - hi_bit));

    // Range end, clipped to the map; only used when the count is nonzero.
    assign range_end  = (COUNT_W+1)'(s_item.block_index) + (COUNT_W+1)'(s_item.block_count);
    assign range_clip = (range_end > MAP_END) ? MAP_END : range_end;
    assign range_last = range_clip - (COUNT_W+1)'(1);

    always_comb begin
        wr_en   = 1'b0;
        wr_data = rd_word;
        if (cmd.alloc_wr) begin
            wr_en   = 1'b1;
            wr_data = alloc_word;
        end else if (cmd.free_wr) begin
            wr_en   = free_bit;
            wr_data = free_word;
        end else if (cmd.range_wr) begin
            wr_en   = 1'b1;
            wr_data = cleared_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            map_mem[word_reg] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg  <= map_mem[word_reg];
            rd_valid_reg <= valid_reg[word_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            not_full_reg <= '0;
        end else if (cmd.mark) begin
            valid_reg    <= '0;
            not_full_reg <= '0;
        end else if (wr_en) begin
            valid_reg[word_reg]    <= 1'b1;
            not_full_reg[word_reg] <= (wr_data != FULL_WORD);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.mark) begin
            count_next = eff_total;
        end else if (cmd.alloc_wr) begin
            count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);
        end else if (cmd.free_wr && free_bit) begin
            count_next = (count_reg == '0) ? count_reg : count_reg - COUNT_W'(1);
        end else if (cmd.range_wr) begin
            count_next = (count_reg > COUNT_W'(pop_reg)) ? count_reg - COUNT_W'(pop_reg) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= TOTAL_RESET;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg      <= s_item;
            word_reg      <= s_item.block_index[INDEX_W-1:BIT_AW];
            scan_grp_reg  <= '0;
            last_word_reg <= range_last[INDEX_W-1:BIT_AW];
            last_bit_reg  <= range_last[BIT_AW-1:0];
            status_reg    <= STATUS_OK;
            granted_reg   <= '0;
        end else begin
            if (cmd.scan_step) begin
                scan_grp_reg <= scan_grp_reg + GROUP_AW'(1);
                if (|grp_bits) begin
                    word_reg <= {scan_grp_reg, grp_enc};
                end else if (scan_grp_reg == '1) begin
                    status_reg <= STATUS_OOM;
                end
            end
            if (cmd.alloc_wr) begin
                granted_reg <= {word_reg, zero_pos};
            end
            if (cmd.free_wr && !free_bit) begin
                status_reg <= STATUS_DOUBLE_FREE;
            end
            if (cmd.range_calc) begin
                cleared_reg <= rd_word & ~range_mask;
                pop_reg     <= popcount32(rd_word & range_mask);
            end
            if (cmd.range_wr && (word_reg != last_word_reg)) begin
                word_reg <= word_reg + WORD_AW'(1);
            end
        end
    end

    // Result register: frees the controller while the item waits downstream.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            m_item_reg.status        <= status_reg;
            m_item_reg.granted_block <= granted_reg;
            m_item_reg.used_total    <= count_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assign sts.grp_hit    = |grp_bits;
    assign sts.grp_last   = (scan_grp_reg == '1);
    assign sts.range_last = (word_reg == last_word_reg);
    assign sts.out_free   = !m_valid_reg || m_ready;

endmodule
